/* rtl/mcm_pkg.sv */
`default_nettype none

package mcm_pkg;

  localparam int unsigned MEM_BYTES_DEF = 131072;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BE_W        = WORD_W / BYTE_W;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_USED_W  = WORD_W + STATUS_W + 1 + 1 + BYTE_W + 1;

  localparam logic [WORD_W-1:0] IN_PORT_RST  = 32'd256;
  localparam logic [WORD_W-1:0] OUT_PORT_RST = 32'd260;
  localparam logic [WORD_W-1:0] FINISH_RST   = 32'd264;
  localparam logic [WORD_W-1:0] HIGH_MEM_RST = 32'd4096;

  localparam logic [BYTE_W-1:0] FINISH_BYTE = 8'hff;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_PRELOAD = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_UNALIGNED = 2'd1,
    STS_RANGE     = 2'd2,
    STS_IGNORED   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_PORT  = 2'd0,
    REG_OUT_PORT = 2'd1,
    REG_FINISH   = 2'd2,
    REG_HIGH_MEM = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  typedef struct packed {
    status_e             status;
    logic                rd_ram;
    logic [WORD_W-1:0]   rdata;
    logic                in_taken;
    logic                out_valid;
    logic [BYTE_W-1:0]   out_byte;
    logic                halted;
    logic                mem_we;
    logic [BE_W-1:0]     mem_be;
  } access_t;

endpackage

`default_nettype wire

/* rtl/mmio_console_memory.sv */
// Channel    Dir  Payload (lowest bit first)
// s_axis     in   tuser: cmd; tdata: addr, wdata, byte_mask, in_byte, in_available
// m_axis     out  tdata: rdata, status, in_taken, out_valid, out_byte, halted
// cfg        in   cfg_we_i, cfg_idx_i, cfg_wdata_i (no read-back)
//
// An item is decoded and its RAM access issued at the edge that accepts it; the
// synchronous RAM read register and the stage-1 register load at that edge, and
// the output register loads from them and offers the result when stage 1 hands
// its item on. One item per cycle is sustained while the output is taken.
// After reset the RAM is cleared one word per cycle, all RAM_WORDS words in turn,
// and no item is accepted until the pass ends. A stalled output holds its item
// and the item behind it; input is refused until space frees up.
`default_nettype none

module mmio_console_memory import mcm_pkg::*; #(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // addr, wdata, byte_mask, in_byte, in_available, zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd
  input  wire logic [CMD_W-1:0]       s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // rdata, status, in_taken, out_valid, out_byte, halted, zero fill
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned RAM_WORDS = (MEM_BYTES + 3) / 4;
  localparam int unsigned AW        = $clog2(RAM_WORDS);

  logic [WORD_W-1:0] in_port_q, out_port_q, finish_q, high_mem_q;
  logic              halt_q;
  state_e            state_q, state_d;
  logic [AW-1:0]     clr_idx_q, clr_idx_d;

  logic [WORD_W-1:0] addr, wdata;
  logic [BE_W-1:0]   byte_mask;
  logic [BYTE_W-1:0] in_byte;
  logic              in_available;

  access_t           acc;
  logic              in_fire, s1_fire, clearing;
  logic              s1_valid_q;
  access_t           s1_acc_q;
  logic              out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic              ram_we;
  logic [BE_W-1:0]   ram_be;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, res_rdata;

  assign addr         = s_axis_tdata[31:0];
  assign wdata        = s_axis_tdata[63:32];
  assign byte_mask    = s_axis_tdata[67:64];
  assign in_byte      = s_axis_tdata[75:68];
  assign in_available = s_axis_tdata[76];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_port_q  <= IN_PORT_RST;
      out_port_q <= OUT_PORT_RST;
      finish_q   <= FINISH_RST;
      high_mem_q <= HIGH_MEM_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IN_PORT:  in_port_q  <= cfg_wdata_i;
        REG_OUT_PORT: out_port_q <= cfg_wdata_i;
        REG_FINISH:   finish_q   <= cfg_wdata_i;
        REG_HIGH_MEM: high_mem_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mcm_access #(
    .MEM_BYTES (MEM_BYTES)
  ) u_access (
    .cmd_i           (s_axis_tuser),
    .addr_i          (addr),
    .wdata_i         (wdata),
    .byte_mask_i     (byte_mask),
    .in_byte_i       (in_byte),
    .in_available_i  (in_available),
    .in_port_addr_i  (in_port_q),
    .out_port_addr_i (out_port_q),
    .finish_addr_i   (finish_q),
    .high_mem_base_i (high_mem_q),
    .halt_i          (halt_q),
    .acc_o           (acc)
  );

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + AW'(1);
        if (clr_idx_q == AW'(RAM_WORDS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: ;
      default: state_d = ST_CLEAR;
    endcase
  end

  assign clearing      = (state_q != ST_RUN);
  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clearing && (!s1_valid_q || s1_fire);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign ram_we    = clearing || (in_fire && acc.mem_we);
  assign ram_be    = clearing ? '1 : acc.mem_be;
  assign ram_waddr = clearing ? clr_idx_q : addr[AW+1:2];
  assign ram_wdata = clearing ? '0 : wdata;

  mcm_ram #(
    .DEPTH (RAM_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .be_i    (ram_be),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire && acc.rd_ram),
    .raddr_i (addr[AW+1:2]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      halt_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      if (in_fire) begin
        halt_q <= acc.halted;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_rdata  = s1_acc_q.rd_ram ? ram_rdata : s1_acc_q.rdata;
  assign out_data_d = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, s1_acc_q.halted,
                       s1_acc_q.out_byte, s1_acc_q.out_valid, s1_acc_q.in_taken,
                       s1_acc_q.status, res_rdata};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_acc_q <= acc;
    end
    if (s1_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

/* rtl/mcm_ram.sv */
`default_nettype none

module mcm_ram import mcm_pkg::*; #(
  parameter int unsigned DEPTH = MEM_BYTES_DEF / BE_W,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [BE_W-1:0]   be_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < BE_W; i++) begin
        if (be_i[i]) begin
          mem[waddr_i][BYTE_W*i +: BYTE_W] <= wdata_i[BYTE_W*i +: BYTE_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/mcm_access.sv */
`default_nettype none

module mcm_access import mcm_pkg::*; #(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [WORD_W-1:0] addr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  input  wire logic [BE_W-1:0]   byte_mask_i,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  input  wire logic              in_available_i,
  input  wire logic [WORD_W-1:0] in_port_addr_i,
  input  wire logic [WORD_W-1:0] out_port_addr_i,
  input  wire logic [WORD_W-1:0] finish_addr_i,
  input  wire logic [WORD_W-1:0] high_mem_base_i,
  input  wire logic              halt_i,
  output access_t                acc_o
);

  logic [WORD_W:0] addr_end;

  assign addr_end = {1'b0, addr_i} + (WORD_W+1)'(3);

  always_comb begin
    acc_o        = '0;
    acc_o.status = STS_OK;
    acc_o.halted = halt_i;
    if (addr_i[1:0] != 2'b00) begin
      acc_o.status = STS_UNALIGNED;
    end else if (addr_end >= (WORD_W+1)'(MEM_BYTES)) begin
      acc_o.status = STS_RANGE;
    end else begin
      case (cmd_e'(cmd_i))
        CMD_READ: begin
          if (addr_i == in_port_addr_i) begin
            if (in_available_i) begin
              acc_o.rdata    = {{(WORD_W-BYTE_W){1'b0}}, in_byte_i};
              acc_o.in_taken = 1'b1;
            end else begin
              acc_o.rdata = '1;
            end
          end else begin
            acc_o.rd_ram = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (addr_i == in_port_addr_i) begin
            acc_o.status = STS_IGNORED;
          end else if (addr_i == out_port_addr_i) begin
            if (byte_mask_i[0]) begin
              acc_o.out_valid = 1'b1;
              acc_o.out_byte  = wdata_i[BYTE_W-1:0];
            end else begin
              acc_o.status = STS_IGNORED;
            end
          end else if (addr_i == finish_addr_i) begin
            if (byte_mask_i[0] && (wdata_i[BYTE_W-1:0] == FINISH_BYTE)) begin
              acc_o.halted = 1'b1;
            end
          end else if (addr_i < high_mem_base_i) begin
            acc_o.status = STS_IGNORED;
          end else begin
            acc_o.mem_we = 1'b1;
            acc_o.mem_be = byte_mask_i;
          end
        end
        CMD_PRELOAD: begin
          acc_o.mem_we = 1'b1;
          acc_o.mem_be = byte_mask_i;
        end
        default: begin
          acc_o.status = STS_IGNORED;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/mcm_checker.sv */
`default_nettype none

module mcm_port_props import mcm_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled output item changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:32] != 2'd0) |->
      (m_axis_tdata[31:0] == '0) && !m_axis_tdata[34] && !m_axis_tdata[35])
    else $error("Failed access shows data or a console event.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[35] |->
      !m_axis_tdata[34] && (m_axis_tdata[31:0] == '0))
    else $error("Console output item also carries read data.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34] |-> (m_axis_tdata[31:8] == '0))
    else $error("Console input read has upper bits set.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[44] |=> !m_axis_tvalid || m_axis_tdata[44])
    else $error("Halted flag dropped.");

endmodule

bind mmio_console_memory mcm_port_props u_mcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
